[src/rbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbp_pkg: shared types and constants of the rational Bezier point evaluator
// Field types, request codes, register map and fixed-point constants.
// ----------------------------------------------------------------------------
package rbp_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic        [15:0] weight_t;
	typedef logic        [16:0] param_t;
	typedef logic        [30:0] frac30_t;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// register map, index taken from paddr[2]
	localparam logic REG_NUM_POINTS = 1'b0;
	localparam logic [4:0] NUM_POINTS_RESET = 5'd2;

	localparam param_t  PARAM_ONE = 17'd65536;
	localparam frac30_t ONE30     = 31'h4000_0000;

	localparam int DIV_BITS = 64;

endpackage

[src/rational_bezier_point.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_bezier_point: rational Bezier curve point evaluator
// An evaluate item runs the power and point steps and then the divider; when
// the weighted basis sum is zero the divider is skipped. A load item goes into the point store.
// Throughput is one item at a time: the single shared 33x33 multiplier runs
// 3 steps per power and 10 per point, then a one-bit-per-cycle divider works
// on each of the three coordinates in turn. Reset clears the sequencer and
// the output valid and sets num_points to 2; the point store is not cleared.
// ----------------------------------------------------------------------------
module rational_bezier_point
	import rbp_pkg::*;
#(
	parameter int MAX_POINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [3:0]  point_index,
	input  coord_t      px,
	input  coord_t      py,
	input  coord_t      pz,
	input  weight_t     weight,
	input  param_t      curve_param,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output coord_t      out_x,
	output coord_t      out_y,
	output coord_t      out_z,
	output logic        zero_denominator
);

	localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam int BW = MAX_POINTS - 1;
	localparam int SW = $clog2(DIV_BITS);
	localparam logic [1:0] CRD_X = 2'd0;
	localparam logic [1:0] CRD_Y = 2'd1;
	localparam logic [1:0] CRD_Z = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_POW_T, ST_POW_U, ST_POW_W,
		ST_TU, ST_TU_W, ST_BIN, ST_BIN_W, ST_WGT, ST_WGT_W,
		ST_NX, ST_NY, ST_NZ, ST_NZ_W,
		ST_DIV_LD, ST_DIV, ST_DIV_END, ST_OUT
	} state_t;

	state_t          state_q;
	logic [4:0]      num_points_q;
	logic [IW-1:0]   n_q, cnt_q, pas_q;
	logic [1:0]      crd_q;
	logic [SW-1:0]   step_q;
	logic            out_valid_q;

	// point store
	coord_t          ctrl_x_q [MAX_POINTS];
	coord_t          ctrl_y_q [MAX_POINTS];
	coord_t          ctrl_z_q [MAX_POINTS];
	weight_t         ctrl_w_q [MAX_POINTS];
	coord_t          rd_x_q, rd_y_q, rd_z_q;
	weight_t         rd_w_q;

	// datapath
	logic [BW-1:0]   binom_q [MAX_POINTS];
	frac30_t         tpow_q  [MAX_POINTS];
	frac30_t         upow_q  [MAX_POINTS];
	frac30_t         t30_q, u30_q, tmp_q, wb_q;
	logic [31:0]     den_q;
	logic signed [63:0] nx_q, ny_q, nz_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_s1;
	logic [DIV_BITS-1:0] quo_q;
	logic [31:0]     rem_q;
	logic            neg_q;
	coord_t          res_x_q, res_y_q, res_z_q;
	logic            res_zero_q;

	logic            in_fire, eval_fire, load_fire, cfg_wr, out_load, last_pt;
	logic [5:0]      eff_cnt;
	logic [IW-1:0]   n_new, cnt_inc, ua;
	param_t          t_clamp;
	logic [32:0]     div_tmp;
	logic            div_bit;
	logic signed [63:0] nsel;
	coord_t          sat_val;

	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_NUM_POINTS) ? {27'd0, num_points_q} : 32'd0;
	assign cfg_wr    = psel && penable && pwrite;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign eval_fire = in_fire && (req_type == REQ_EVAL);
	assign load_fire = in_fire && (req_type == REQ_LOAD) && (32'(point_index) < MAX_POINTS);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign cnt_inc   = cnt_q + IW'(1);
	assign last_pt   = (cnt_q == n_q);

	always_comb begin
		if (num_points_q == 5'd0) begin
			eff_cnt = 6'd1;
		end else if (32'(num_points_q) > MAX_POINTS) begin
			eff_cnt = 6'(MAX_POINTS);
		end else begin
			eff_cnt = {1'b0, num_points_q};
		end
		n_new   = IW'(eff_cnt - 6'd1);
		t_clamp = (curve_param > PARAM_ONE) ? PARAM_ONE : curve_param;
	end

	// shared multiplier operand select
	assign ua = (state_q == ST_TU) ? (n_q - cnt_q) : cnt_q;
	always_comb begin
		ma = $signed({2'b00, tpow_q[cnt_q]});
		mb = $signed({2'b00, t30_q});
		case (state_q)
			ST_POW_U: begin
				ma = $signed({2'b00, upow_q[ua]});
				mb = $signed({2'b00, u30_q});
			end
			ST_TU: begin
				mb = $signed({2'b00, upow_q[ua]});
			end
			ST_BIN: begin
				ma = $signed(33'(binom_q[cnt_q]));
				mb = $signed({2'b00, tmp_q});
			end
			ST_WGT: begin
				ma = $signed({2'b00, tmp_q});
				mb = $signed({17'd0, rd_w_q});
			end
			ST_NX: begin
				ma = $signed({2'b00, wb_q});
				mb = {rd_x_q[31], rd_x_q};
			end
			ST_NY: begin
				ma = $signed({2'b00, wb_q});
				mb = {rd_y_q[31], rd_y_q};
			end
			ST_NZ: begin
				ma = $signed({2'b00, wb_q});
				mb = {rd_z_q[31], rd_z_q};
			end
			default: begin
			end
		endcase
	end

	// divider step and result saturation
	always_comb begin
		div_tmp = {rem_q, quo_q[DIV_BITS-1]};
		div_bit = (div_tmp >= {1'b0, den_q});
		case (crd_q)
			CRD_X:   nsel = nx_q;
			CRD_Y:   nsel = ny_q;
			default: nsel = nz_q;
		endcase
		if (neg_q) begin
			sat_val = (quo_q > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
		end else begin
			sat_val = (quo_q > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
		end
	end

	// point store: write on load, registered read at the current point
	always_ff @(posedge clk) begin
		if (load_fire) begin
			ctrl_x_q[IW'(point_index)] <= px;
			ctrl_y_q[IW'(point_index)] <= py;
			ctrl_z_q[IW'(point_index)] <= pz;
			ctrl_w_q[IW'(point_index)] <= weight;
		end
		rd_x_q <= ctrl_x_q[cnt_q];
		rd_y_q <= ctrl_y_q[cnt_q];
		rd_z_q <= ctrl_z_q[cnt_q];
		rd_w_q <= ctrl_w_q[cnt_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_points_q <= NUM_POINTS_RESET;
			n_q          <= '0;
			cnt_q        <= '0;
			pas_q        <= '0;
			crd_q        <= CRD_X;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_NUM_POINTS)) begin
				num_points_q <= pwdata[4:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q != ST_IDLE) && (pas_q < n_q)) begin
				pas_q <= pas_q + IW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (eval_fire) begin
						n_q   <= n_new;
						cnt_q <= '0;
						pas_q <= '0;
						state_q <= (n_new == '0) ? ST_TU : ST_POW_T;
					end
				end
				ST_POW_T: state_q <= ST_POW_U;
				ST_POW_U: state_q <= ST_POW_W;
				ST_POW_W: begin
					if (cnt_inc == n_q) begin
						cnt_q   <= '0;
						state_q <= ST_TU;
					end else begin
						cnt_q   <= cnt_inc;
						state_q <= ST_POW_T;
					end
				end
				ST_TU:    state_q <= ST_TU_W;
				ST_TU_W:  state_q <= ST_BIN;
				ST_BIN:   state_q <= ST_BIN_W;
				ST_BIN_W: state_q <= ST_WGT;
				ST_WGT:   state_q <= ST_WGT_W;
				ST_WGT_W: state_q <= ST_NX;
				ST_NX:    state_q <= ST_NY;
				ST_NY:    state_q <= ST_NZ;
				ST_NZ:    state_q <= ST_NZ_W;
				ST_NZ_W: begin
					if (!last_pt) begin
						cnt_q   <= cnt_inc;
						state_q <= ST_TU;
					end else if (den_q == 32'd0) begin
						state_q <= ST_OUT;
					end else begin
						crd_q   <= CRD_X;
						state_q <= ST_DIV_LD;
					end
				end
				ST_DIV_LD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(DIV_BITS - 1)) begin
						state_q <= ST_DIV_END;
					end
				end
				ST_DIV_END: begin
					if (crd_q == CRD_Z) begin
						state_q <= ST_OUT;
					end else begin
						crd_q   <= crd_q + 2'd1;
						state_q <= ST_DIV_LD;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if ((state_q != ST_IDLE) && (pas_q < n_q)) begin
			// one Pascal row per cycle, all lanes from the old row
			for (int j = 1; j < MAX_POINTS; j++) begin
				binom_q[j] <= binom_q[j] + binom_q[j-1];
			end
		end
		case (state_q)
			ST_IDLE: begin
				if (eval_fire) begin
					for (int j = 0; j < MAX_POINTS; j++) begin
						binom_q[j] <= (j == 0) ? BW'(1) : '0;
					end
					tpow_q[0] <= ONE30;
					upow_q[0] <= ONE30;
					t30_q     <= {t_clamp, 14'd0};
					u30_q     <= ONE30 - {t_clamp, 14'd0};
					den_q     <= '0;
					nx_q      <= '0;
					ny_q      <= '0;
					nz_q      <= '0;
				end
			end
			ST_POW_U: tpow_q[cnt_inc] <= prod_s1[60:30];
			ST_POW_W: upow_q[cnt_inc] <= prod_s1[60:30];
			ST_TU_W:  tmp_q <= prod_s1[60:30];
			ST_BIN_W: tmp_q <= prod_s1[30:0];
			ST_WGT_W: begin
				wb_q  <= prod_s1[46:16];
				den_q <= den_q + {1'b0, prod_s1[46:16]};
			end
			ST_NY:    nx_q <= nx_q + prod_s1[63:0];
			ST_NZ:    ny_q <= ny_q + prod_s1[63:0];
			ST_NZ_W: begin
				nz_q <= nz_q + prod_s1[63:0];
				res_zero_q <= last_pt && (den_q == 32'd0);
				if (last_pt && (den_q == 32'd0)) begin
					res_x_q    <= '0;
					res_y_q    <= '0;
					res_z_q    <= '0;
				end
			end
			ST_DIV_LD: begin
				// divide magnitudes, restore the sign at the end
				neg_q <= nsel[63];
				quo_q <= nsel[63] ? 64'(-nsel) : 64'(nsel);
				rem_q <= '0;
			end
			ST_DIV: begin
				quo_q <= {quo_q[DIV_BITS-2:0], div_bit};
				rem_q <= div_bit ? 32'(div_tmp - {1'b0, den_q}) : div_tmp[31:0];
			end
			ST_DIV_END: begin
				case (crd_q)
					CRD_X:   res_x_q <= sat_val;
					CRD_Y:   res_y_q <= sat_val;
					default: res_z_q <= sat_val;
				endcase
			end
			ST_OUT: begin
				if (out_load) begin
					out_x            <= res_x_q;
					out_y            <= res_y_q;
					out_z            <= res_z_q;
					zero_denominator <= res_zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	logic pt_phase;
	assign pt_phase = (state_q == ST_TU) || (state_q == ST_TU_W) || (state_q == ST_BIN)
		|| (state_q == ST_BIN_W) || (state_q == ST_WGT) || (state_q == ST_WGT_W)
		|| (state_q == ST_NX) || (state_q == ST_NY) || (state_q == ST_NZ)
		|| (state_q == ST_NZ_W);

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != 32'd0))
		else $error("division started with zero denominator");

	a_pt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pt_phase |-> (cnt_q <= n_q))
		else $error("point counter beyond degree");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && zero_denominator) |-> (out_x == 0 && out_y == 0 && out_z == 0))
		else $error("zero denominator with nonzero coordinates");

endmodule

[tb/sv/rational_bezier_point_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_bezier_point_test: self-checking bench for the Bezier point evaluator
// Loads weighted control points and evaluates the curve under several point
// counts, with random idling on both channels. Every result is checked
// against a fixed-point predictor of the rational Bezier sum.
// ----------------------------------------------------------------------------
module rational_bezier_point_test
	import rbp_pkg::*;
();

	localparam int SLOTS      = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT = 500;

	typedef struct {
		logic    kind;
		int      slot;
		coord_t  x, y, z;
		weight_t w;
		param_t  t;
	} curve_req_t;

	typedef struct {
		coord_t x, y, z;
		logic   zd;
	} curve_pt_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, req_type;
	logic [3:0] point_index;
	coord_t px, py, pz;
	weight_t weight;
	param_t curve_param;
	logic out_valid, out_stall, zero_denominator;
	coord_t out_x, out_y, out_z;

	rational_bezier_point DUT (.*);

	curve_req_t pending_reqs[$];
	curve_pt_t  expected_pts[$];
	curve_req_t cur;
	coord_t  slot_x[SLOTS], slot_y[SLOTS], slot_z[SLOTS];
	weight_t slot_w[SLOTS];
	int      points_used;
	int      errors;
	bit      calm;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic coord_t clamp32(longint q);
		if (q > 64'sd2147483647) return 32'h7fff_ffff;
		if (q < -64'sd2147483648) return 32'h8000_0000;
		return coord_t'(q);
	endfunction

	function automatic curve_pt_t bezier_point(param_t tp);
		longint unsigned binom[SLOTS], tpw[SLOTS], upw[SLOTS];
		longint unsigned tv, t30, u30, b, wb, den;
		longint nx, ny, nz;
		int cnt, n;
		curve_pt_t r;
		cnt = points_used;
		if (cnt < 1) cnt = 1;
		if (cnt > SLOTS) cnt = SLOTS;
		n = cnt - 1;
		tv = (tp > PARAM_ONE) ? 65536 : tp;
		t30 = tv << 14;
		u30 = (64'd1 << 30) - t30;
		foreach (binom[k]) binom[k] = 0;
		binom[0] = 1;
		for (int row = 1; row <= n; row++)
			for (int k = row; k >= 1; k--)
				binom[k] += binom[k - 1];
		tpw[0] = 64'd1 << 30;
		upw[0] = 64'd1 << 30;
		for (int k = 1; k <= n; k++) begin
			tpw[k] = (tpw[k - 1] * t30) >> 30;
			upw[k] = (upw[k - 1] * u30) >> 30;
		end
		den = 0;
		nx = 0;
		ny = 0;
		nz = 0;
		for (int k = 0; k <= n; k++) begin
			b = binom[k] * ((tpw[k] * upw[n - k]) >> 30);
			wb = (b * slot_w[k]) >> 16;
			den += wb;
			nx += longint'(wb) * longint'(slot_x[k]);
			ny += longint'(wb) * longint'(slot_y[k]);
			nz += longint'(wb) * longint'(slot_z[k]);
		end
		if (den == 0) begin
			r = '{0, 0, 0, 1'b1};
		end else begin
			r.x = clamp32(nx / longint'(den));
			r.y = clamp32(ny / longint'(den));
			r.z = clamp32(nz / longint'(den));
			r.zd = 1'b0;
		end
		return r;
	endfunction

	// driver: accept the current item, then present the next or idle
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			req_type    <= REQ_LOAD;
			point_index <= '0;
			px          <= '0;
			py          <= '0;
			pz          <= '0;
			weight      <= '0;
			curve_param <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (cur.kind == REQ_LOAD) begin
					slot_x[cur.slot] = cur.x;
					slot_y[cur.slot] = cur.y;
					slot_z[cur.slot] = cur.z;
					slot_w[cur.slot] = cur.w;
				end else begin
					expected_pts.insert(expected_pts.size(), bezier_point(cur.t));
				end
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					gap_left = $urandom_range(1, 19) - 1;
					in_valid <= 1'b0;
				end else begin
					cur = pending_reqs.pop_front();
					req_type    <= cur.kind;
					point_index <= cur.slot[3:0];
					px          <= cur.x;
					py          <= cur.y;
					pz          <= cur.z;
					weight      <= cur.w;
					curve_param <= cur.t;
					in_valid    <= 1'b1;
				end
			end
		end
	end

	// monitor: check each result, stall in bursts
	int hold_left;
	curve_pt_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pts.size() == 0) begin
					$error("unexpected result x=%0d y=%0d z=%0d", out_x, out_y, out_z);
					errors++;
				end else begin
					want = expected_pts.pop_front();
					if (out_x !== want.x) begin
						$error("out_x expected %0d got %0d", want.x, out_x);
						errors++;
					end
					if (out_y !== want.y) begin
						$error("out_y expected %0d got %0d", want.y, out_y);
						errors++;
					end
					if (out_z !== want.z) begin
						$error("out_z expected %0d got %0d", want.z, out_z);
						errors++;
					end
					if (zero_denominator !== want.zd) begin
						$error("zero_denominator expected %0d got %0d",
							want.zd, zero_denominator);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				hold_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no item moving on either channel and no APB access
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_load(int slot, coord_t x, coord_t y, coord_t z, weight_t w);
		curve_req_t r;
		r = '{REQ_LOAD, slot, x, y, z, w, param_t'($urandom)};
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	task automatic add_eval(param_t t);
		curve_req_t r;
		r = '{REQ_EVAL, $urandom_range(0, SLOTS - 1), $urandom, $urandom, $urandom,
			weight_t'($urandom), t};
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	function automatic coord_t any_coord();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return coord_t'($urandom_range(0, 2000000)) - 1000000;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic param_t any_param();
		case ($urandom_range(0, 19))
			0, 1: return 17'd0;
			2, 3: return PARAM_ONE;
			4: return param_t'($urandom_range(65537, 131071));
			default: return param_t'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic add_random(int count);
		weight_t w;
		repeat (count) begin
			if ($urandom_range(0, 9) < 3) begin
				case ($urandom_range(0, 7))
					0: w = 16'd0;
					1: w = 16'hffff;
					default: w = weight_t'($urandom);
				endcase
				add_load($urandom_range(0, SLOTS - 1), any_coord(), any_coord(),
					any_coord(), w);
			end else begin
				add_eval(any_param());
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || expected_pts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic reg_write(logic index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == REG_NUM_POINTS) points_used = value[4:0];
	endtask

	int counts[8] = '{1, 16, 0, 31, 5, 9, 3, 16};

	initial begin
		errors = 0;
		calm = 1'b0;
		points_used = NUM_POINTS_RESET;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot first; the first two weightless give a zero sum
		for (int k = 0; k < SLOTS; k++)
			add_load(k, (k % 2) ? 32'h7fff_ffff : 32'h8000_0000,
				(k % 2) ? 32'h8000_0000 : 32'h7fff_ffff, coord_t'(k << 16),
				(k < 2) ? 16'd0 : 16'hffff);
		add_eval(17'd32768);
		add_load(0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 16'hffff);
		add_eval(17'd0);
		add_eval(PARAM_ONE);
		add_eval(17'h1ffff);
		add_load(1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 16'd1);
		add_eval(17'd1);
		add_eval(17'd65535);
		add_eval(17'd32768);
		wait_idle();

		// the unused register index is ignored
		reg_write(1'b1, 32'hffff_ffff);
		for (int p = 0; p < 8; p++) begin
			reg_write(REG_NUM_POINTS, counts[p]);
			if (p == 7) calm = 1'b1;
			add_random(85);
			wait_idle();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
src/rbp_pkg.sv
src/rational_bezier_point.sv
tb/sv/rational_bezier_point_test.sv
